### design/svf_pkg.sv
package svf_pkg;

    // default widths of the sample and integrator words
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int STATE_WIDTH_DEF  = 32;

    // register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int RES_W      = 24;
    localparam int MODE_W     = 3;
    localparam int SHELF_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF = 2'd3;

    localparam logic [MODE_W-1:0] MODE_HIGH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOW     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BAND    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHELF   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOTCH   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALLPASS = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PEAK    = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h100000;
    localparam logic [RES_W-1:0]  RES_ONE    = 24'h800000;

    // fraction bits of the coefficients
    localparam int GAIN_FRAC  = 20;
    localparam int K_FRAC     = 23;
    localparam int SHELF_FRAC = 22;
    localparam int K_W        = 25;

    // serial multiplier coefficient width and denominator width
    localparam int MUL_B_W = 26;
    localparam int DEN_W   = 30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GG,
        ST_GK,
        ST_NUM,
        ST_DIV,
        ST_V2,
        ST_KV,
        ST_SF,
        ST_OUT
    } svf_state_t;

endpackage

### design/svf_sample_if.sv
interface svf_sample_if import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

### design/svf_result_if.sv
interface svf_result_if import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

### design/svf_cfg_if.sv
interface svf_cfg_if import svf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/svf_mul.sv
module svf_mul import svf_pkg::*; #(
    parameter int PW = 59,
    parameter int BW = MUL_B_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [PW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic                 done,
    output logic signed [PW-1:0] p
);
    localparam int CW = $clog2(BW);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] a_reg;
    logic        [BW-1:0] b_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [PW-1:0] addend;

    // msb first; the top bit of b has negative weight
    always_comb
    begin
        if (!b_reg[BW-1])
            addend = '0;
        else if (cnt_reg == CW'(BW - 1))
            addend = -a_reg;
        else
            addend = a_reg;
        acc_next = (acc_reg <<< 1) + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            cnt_reg <= CW'(BW - 1);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule

### design/svf_div.sv
module svf_div import svf_pkg::*; #(
    parameter int NW = 59,
    parameter int DW = DEN_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          qbit;

    // restoring division on the magnitude, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        qbit   = !diff[DW+1];
        if (qbit)
            rem_next = diff[DW-1:0];
        else
            rem_next = rem_sh[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NW-1];
            q_reg   <= num[NW-1] ? NW'(-num) : NW'(num);
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= CW'(NW - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NW-2:0], qbit};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

### design/state_variable_filter.sv
// one item at a time: a single shift-add multiplier (one coefficient bit per cycle) and a
// restoring divider (one quotient bit per cycle) do all the products and the division
// a new item is taken only in idle, once the previous one has passed through the sequencer;
// the next item is taken while the previous result waits in the output register
// reset: integrators cleared, gain 1.0, resonance 0, low-pass mode, shelf factor 0
module state_variable_filter import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    svf_sample_if.sink    sample,
    svf_result_if.source  result,
    svf_cfg_if.sink       cfg
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int STW = STATE_WIDTH;
    // operand pre-shift for wide state words
    localparam int G   = (STW > 38) ? STW - 38 : 0;
    // product / numerator width
    localparam int PW  = STW - G + 27;
    // headroom width for sums before saturation
    localparam int YW  = STW + 32;

    localparam logic signed [YW-1:0] ST_MAX  = {{(YW-STW+1){1'b0}}, {(STW-1){1'b1}}};
    localparam logic signed [YW-1:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [YW-1:0] SMP_MAX = {{(YW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [YW-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [YW-1:0] SMP_ONE = SMP_MAX + YW'(1);
    localparam logic [DEN_W-1:0]     DEN_ONE = DEN_W'(1) << GAIN_FRAC;

    function automatic logic signed [STW-1:0] sat_st(input logic signed [YW-1:0] v);
        logic signed [YW-1:0] c;
        begin
            if (v > ST_MAX)
                c = ST_MAX;
            else if (v < ST_MIN)
                c = ST_MIN;
            else
                c = v;
            return c[STW-1:0];
        end
    endfunction

    // configuration registers
    logic        [GAIN_W-1:0]  gain_reg;
    logic        [RES_W-1:0]   res_reg;
    logic        [MODE_W-1:0]  mode_reg;
    logic signed [SHELF_W-1:0] shelf_reg;

    // sequencer and datapath registers
    svf_state_t               state_reg, state_next;
    logic                     launched_reg, launched_next;
    logic signed [SW-1:0]     x_reg, x_next;
    logic        [DEN_W-1:0]  den_reg, den_next;
    logic signed [PW-1:0]     num_reg, num_next;
    logic signed [STW-1:0]    v1_reg, v1_next;
    logic signed [STW-1:0]    v2_reg, v2_next;
    logic signed [PW-1:0]     kv_reg, kv_next;
    logic signed [PW-1:0]     t_reg, t_next;
    logic signed [STW-1:0]    ic1_reg, ic1_next;
    logic signed [STW-1:0]    ic2_reg, ic2_next;

    // output register
    logic                     res_valid_reg, res_valid_next;
    logic signed [SW-1:0]     out_sample_reg, out_sample_next;
    logic                     clipped_reg, clipped_next;

    // shared units
    logic                     mul_start, mul_done;
    logic signed [PW-1:0]     mul_a, mul_p;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                     div_start, div_done;
    logic signed [PW-1:0]     div_q;

    logic        [RES_W-1:0]  r_w;
    logic        [K_W-1:0]    k_w;
    logic signed [MUL_B_W-1:0] g_b, k_b, s_b;
    logic signed [STW-1:0]    v3_w;
    logic signed [YW-1:0]     y_w, y_sat;
    logic                     y_hit;

    // damping k = 2 - 2*resonance, resonance limited to 1.0
    always_comb
    begin
        r_w = (res_reg > RES_ONE) ? RES_ONE : res_reg;
        k_w = (K_W'(1) << (K_FRAC + 1)) - {r_w, 1'b0};
        g_b = MUL_B_W'({1'b0, gain_reg});
        k_b = MUL_B_W'({1'b0, k_w});
        s_b = MUL_B_W'(shelf_reg);
        v3_w = sat_st(YW'(x_reg) - YW'(ic2_reg));
    end

    // filtered sample from the input and the solved band and low outputs, saturated to the sample range
    always_comb
    begin
        case (mode_reg)
            MODE_HIGH:    y_w = YW'(x_reg) - YW'(kv_reg) - YW'(v2_reg);
            MODE_LOW:     y_w = YW'(v2_reg);
            MODE_BAND:    y_w = YW'(v1_reg);
            MODE_SHELF:   y_w = YW'(x_reg) + (YW'(t_reg) <<< 1);
            MODE_NOTCH:   y_w = YW'(x_reg) - (YW'(kv_reg) <<< 1);
            MODE_ALLPASS: y_w = YW'(x_reg) - (YW'(kv_reg) <<< 2);
            MODE_PEAK:
            begin
                y_w = (YW'(v2_reg) <<< 1) - YW'(x_reg) + YW'(kv_reg);
                if (y_w > SMP_ONE)
                    y_w = SMP_ONE;
            end
            default:      y_w = '0;
        endcase
        y_hit = 1'b0;
        if (y_w > SMP_MAX)
        begin
            y_sat = SMP_MAX;
            y_hit = 1'b1;
        end
        else if (y_w < SMP_MIN)
        begin
            y_sat = SMP_MIN;
            y_hit = 1'b1;
        end
        else
            y_sat = y_w;
    end

    // sequencer: den, numerator, divide, then the products that follow
    always_comb
    begin
        state_next      = state_reg;
        launched_next   = launched_reg;
        x_next          = x_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        kv_next         = kv_reg;
        t_next          = t_reg;
        ic1_next        = ic1_reg;
        ic2_next        = ic2_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        out_sample_next = out_sample_reg;
        clipped_next    = clipped_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;
        mul_a           = PW'({1'b0, gain_reg});
        mul_b           = g_b;

        case (state_reg)
            ST_GG, ST_GK, ST_NUM, ST_V2, ST_KV, ST_SF:
            begin
                mul_start = !launched_reg;
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (mul_done)
                    launched_next = 1'b0;
            end
            ST_DIV:
            begin
                div_start = !launched_reg;
                if (!launched_reg)
                    launched_next = 1'b1;
                else if (div_done)
                    launched_next = 1'b0;
            end
            default:
                launched_next = 1'b0;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    x_next     = sample.in_sample;
                    state_next = ST_GG;
                end
            end
            ST_GG:
            begin
                if (mul_done)
                begin
                    den_next   = DEN_ONE + DEN_W'(mul_p >>> GAIN_FRAC);
                    state_next = ST_GK;
                end
            end
            ST_GK:
            begin
                mul_b = k_b;
                if (mul_done)
                begin
                    den_next   = den_reg + DEN_W'(mul_p >>> K_FRAC);
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                mul_a = PW'(v3_w >>> G);
                if (mul_done)
                begin
                    num_next   = mul_p + (PW'(ic1_reg >>> G) <<< GAIN_FRAC);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    v1_next    = sat_st(YW'(div_q) <<< G);
                    state_next = ST_V2;
                end
            end
            ST_V2:
            begin
                mul_a = PW'(v1_reg >>> G);
                if (mul_done)
                begin
                    v2_next    = sat_st(YW'(mul_p >>> (GAIN_FRAC - G)) + YW'(ic2_reg));
                    state_next = ST_KV;
                end
            end
            ST_KV:
            begin
                mul_a = PW'(v1_reg >>> G);
                mul_b = k_b;
                if (mul_done)
                begin
                    kv_next    = PW'(mul_p >>> (K_FRAC - G));
                    ic1_next   = sat_st((YW'(v1_reg) <<< 1) - YW'(ic1_reg));
                    ic2_next   = sat_st((YW'(v2_reg) <<< 1) - YW'(ic2_reg));
                    state_next = ST_SF;
                end
            end
            ST_SF:
            begin
                mul_a = PW'(kv_reg >>> G);
                mul_b = s_b;
                if (mul_done)
                begin
                    t_next     = PW'(mul_p >>> (SHELF_FRAC - G));
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    out_sample_next = y_sat[SW-1:0];
                    clipped_next    = y_hit;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    svf_mul #(
        .PW (PW),
        .BW (MUL_B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    svf_div #(
        .NW (PW),
        .DW (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // control state, configuration and integrators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            ic1_reg       <= '0;
            ic2_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            res_reg       <= '0;
            mode_reg      <= MODE_LOW;
            shelf_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            res_valid_reg <= res_valid_next;
            ic1_reg       <= ic1_next;
            ic2_reg       <= ic2_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_GAIN:  gain_reg  <= cfg.data[GAIN_W-1:0];
                    REG_RES:   res_reg   <= cfg.data[RES_W-1:0];
                    REG_MODE:  mode_reg  <= cfg.data[MODE_W-1:0];
                    REG_SHELF: shelf_reg <= cfg.data[SHELF_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        v1_reg         <= v1_next;
        v2_reg         <= v2_next;
        kv_reg         <= kv_next;
        t_reg          <= t_next;
        out_sample_reg <= out_sample_next;
        clipped_reg    <= clipped_next;
    end

    assign sample.ready      = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = res_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign result.clipped    = clipped_reg;
endmodule

### tb/svf_checker.sv
`timescale 1ns / 100ps

module svf_checker import svf_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    svf_sample_if  smp,
    svf_result_if  res,
    svf_cfg_if     cfg,
    output int     errors,
    output int     pending
);

    typedef struct packed {
        logic signed [23:0] out_sample;
        logic               clipped;
    } filt_out_t;

    filt_out_t expected_out[$];

    // shadow of the register file and the integrators
    logic [GAIN_W-1:0]         gain_q;
    logic [RES_W-1:0]          res_q;
    logic [MODE_W-1:0]         mode_q;
    logic signed [SHELF_W-1:0] shelf_q;
    longint                    integ_a;
    longint                    integ_b;

    function automatic longint clamp(longint v, int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin hit = 1; return hi; end
        if (v < lo) begin hit = 1; return lo; end
        return v;
    endfunction

    function automatic filt_out_t filter_sample(logic signed [23:0] smp_in);
        longint x, g, rr, k, den, v3, num, v1, v2, kv, y;
        bit hit;
        bit dummy;
        filt_out_t r;
        x  = smp_in;
        g  = gain_q;
        rr = (res_q > RES_ONE) ? RES_ONE : res_q;
        k  = (longint'(1) << 24) - 2 * rr;
        den = (longint'(1) << 20) + ((g * g) >> 20) + ((g * k) >> 23);
        hit = 0;
        dummy = 0;
        v3  = clamp(x - integ_b, 32, dummy);
        num = g * v3 + integ_a * (longint'(1) << 20);
        v1  = clamp(num / den, 32, dummy);
        v2  = clamp(((v1 * g) >>> 20) + integ_b, 32, dummy);
        integ_a = clamp(2 * v1 - integ_a, 32, dummy);
        integ_b = clamp(2 * v2 - integ_b, 32, dummy);
        kv = (v1 * k) >>> 23;
        case (mode_q)
            MODE_HIGH:    y = x - kv - v2;
            MODE_LOW:     y = v2;
            MODE_BAND:    y = v1;
            MODE_SHELF:   y = x + 2 * ((kv * longint'(shelf_q)) >>> 22);
            MODE_NOTCH:   y = x - 2 * kv;
            MODE_ALLPASS: y = x - 4 * kv;
            MODE_PEAK:
            begin
                y = 2 * v2 - x + kv;
                if (y > (longint'(1) << 23))
                    y = longint'(1) << 23;
            end
            default:      y = 0;
        endcase
        y = clamp(y, 24, hit);
        r.out_sample = y[23:0];
        r.clipped    = hit;
        return r;
    endfunction

    assign pending = expected_out.size();

    always @(posedge clk or negedge rst_n)
    begin
        filt_out_t got;
        filt_out_t exp_o;
        if (!rst_n)
        begin
            gain_q  <= GAIN_RESET;
            res_q   <= '0;
            mode_q  <= MODE_LOW;
            shelf_q <= '0;
            integ_a = 0;
            integ_b = 0;
            expected_out.delete();
            errors = 0;
        end
        else
        begin
            // config writes only happen while idle, so no ordering issue with samples
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GAIN:  gain_q  <= cfg.data[GAIN_W-1:0];
                    REG_RES:   res_q   <= cfg.data[RES_W-1:0];
                    REG_MODE:  mode_q  <= cfg.data[MODE_W-1:0];
                    REG_SHELF: shelf_q <= cfg.data[SHELF_W-1:0];
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                expected_out.push_back(filter_sample(smp.in_sample));
            if (res.valid && res.ready)
            begin
                got.out_sample = res.out_sample;
                got.clipped    = res.clipped;
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result item: out_sample %0d clipped %0b",
                           got.out_sample, got.clipped);
                    errors++;
                end
                else
                begin
                    exp_o = expected_out.pop_front();
                    if (got.out_sample !== exp_o.out_sample)
                    begin
                        $error("out_sample mismatch: expected %0d actual %0d",
                               exp_o.out_sample, got.out_sample);
                        errors++;
                    end
                    if (got.clipped !== exp_o.clipped)
                    begin
                        $error("clipped mismatch: expected %0b actual %0b",
                               exp_o.clipped, got.clipped);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import svf_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    bit   no_gaps;     // set for phases that run back to back

    svf_sample_if smp_if ();
    svf_result_if res_if ();
    svf_cfg_if    cfg_if ();

    state_variable_filter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // watches all three channels, predicts and compares
    svf_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .smp     (smp_if),
        .res     (res_if),
        .cfg     (cfg_if),
        .errors  (errors),
        .pending (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // result side stalls at random, held for a random stretch
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            // ready high for a while, then a gap
            res_if.ready <= !res_if.ready || no_gaps;
            stall_left   <= res_if.ready ? pick_gap() : $urandom_range(0, 30);
        end
    end

    // one sample item, optional idle before it, waits for the handshake
    task automatic send_sample(logic [23:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.in_sample <= s;
        do @(posedge clk); while (!smp_if.ready);
    endtask

    // valid stays up so writes can follow back to back; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // drop sample valid and wait until every result is back
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic setup(logic [23:0] g, logic [23:0] r, logic [23:0] m, logic [23:0] sf);
        drain();
        write_reg(REG_GAIN, g);
        write_reg(REG_RES, r);
        write_reg(REG_MODE, m);
        write_reg(REG_SHELF, sf);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_gain();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return 24'hFFFFFF;
        if (p < 6)  return 24'($urandom_range(24'h010000, 24'h200000));
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic logic [23:0] rand_res();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return RES_ONE;
        if (p == 2) return 24'($urandom_range(24'h800001, 24'hFFFFFF));
        return 24'($urandom_range(0, 24'h800000));
    endfunction

    function automatic logic [23:0] rand_shelf();
        int p;
        p = $urandom_range(0, 5);
        if (p == 0) return 24'h7FFFFF;
        if (p == 1) return 24'h800000;
        return 24'($urandom());
    endfunction

    logic [23:0] edge_samples[5] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                     24'h000001, 24'hFFFFFF};

    initial
    begin
        int n;
        no_gaps          = 1'b0;
        rst_n            = 1'b0;
        smp_if.valid     = 1'b0;
        smp_if.in_sample = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings (low-pass, gain 1.0) against full-scale and near-zero edge samples
        foreach (edge_samples[i])
            send_sample(edge_samples[i]);

        // every mode including the unused code, with extreme coefficients:
        // resonance above 1.0, unit and max gain, shelf factor at both ends
        for (int m = 0; m < 8; m++)
        begin
            setup((m % 2) ? 24'hFFFFFF : 24'h100000,
                  (m % 3 == 0) ? 24'hFFFFFF : ((m % 3 == 1) ? 24'h000000 : RES_ONE),
                  {21'($urandom()), 3'(m)},
                  (m < 4) ? 24'h7FFFFF : 24'h800000);
            send_sample(24'h7FFFFF);
            send_sample(24'h800000);
        end
        // zero gain leaves the integrators idle
        setup(24'h000000, 24'h400000, {21'($urandom()), MODE_PEAK}, 24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h123456);

        // random phases, each with fresh settings
        n = 0;
        while (n < 450)
        begin
            int len;
            setup(rand_gain(), rand_res(), {21'($urandom()), 3'($urandom_range(0, 7))},
                  rand_shelf());
            no_gaps = ($urandom_range(0, 4) == 0);
            len = $urandom_range(10, 30);
            repeat (len)
            begin
                // mostly full-scale random, sometimes small or extreme
                case ($urandom_range(0, 7))
                    0:       send_sample(edge_samples[3'($urandom_range(0, 4))]);
                    1:       send_sample(24'($signed($urandom_range(0, 2000)) - 1000));
                    default: send_sample(24'($urandom()));
                endcase
                n++;
            end
            no_gaps = 1'b0;
        end
        // mode back to reset value at the end so it is written once more
        setup(GAIN_RESET, 24'h000000, {21'h0, MODE_LOW}, 24'h000000);
        send_sample(24'h400000);

        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // catch any stray result after the last expected one
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit well above the slowest legal run
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
